// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// File: rtl/bole_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list engine package
// Request and status codes, cell control modes and the cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package bole_pkg;

   localparam int WORD_W   = 32;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 3;

   // request kinds; the unused code falls to a default arm
   typedef enum logic [KIND_W-1:0] {
      KIND_ADD_FRONT    = 3'd0,
      KIND_ADD_BACK     = 3'd1,
      KIND_INSERT       = 3'd2,
      KIND_REMOVE_FRONT = 3'd3,
      KIND_REMOVE_BACK  = 3'd4,
      KIND_REMOVE_KEY   = 3'd5,
      KIND_FIND         = 3'd6
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_EMPTY     = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_BAD_POS   = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   // what every cell does on the update cycle
   typedef enum logic [1:0] {
      CELL_HOLD        = 2'd0,
      CELL_OPEN        = 2'd1,
      CELL_CLOSE_POS   = 2'd2,
      CELL_CLOSE_MATCH = 2'd3
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type             mode;
      logic                      match_en;
      logic signed [WORD_W-1:0]  value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/bole_channels.sv
// ----------------------------------------------------------------------------
// Ordered list engine channels
// Valid/ready request and response interfaces with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none

interface bole_req_if #(
   parameter int CW = 7
);
   logic                               valid;
   logic                               ready;
   logic [bole_pkg::KIND_W-1:0]        kind;
   logic signed [bole_pkg::WORD_W-1:0] value;
   logic [CW-1:0]                      position;

   modport source (output valid, output kind, output value, output position, input ready);
   modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface bole_rsp_if #(
   parameter int CW = 7
);
   logic                          valid;
   logic                          ready;
   logic [bole_pkg::STATUS_W-1:0] status;
   logic                          present;
   logic [CW-1:0]                 length;

   modport source (output valid, output status, output present, output length, input ready);
   modport sink   (input valid, input status, input present, input length, output ready);
endinterface

`default_nettype wire

// File: rtl/bole_cell.sv
// ----------------------------------------------------------------------------
// List cell
// Holds one element, registers its key match and shifts with its neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module bole_cell #(
   parameter int CW    = 7,
   parameter int INDEX = 0
) (
   input  wire                                   clock,
   input  wire bole_pkg::cell_ctrl_type          ctrl,
   input  wire  [CW-1:0]                         pos,
   input  wire  [CW-1:0]                         count,
   input  wire logic signed [bole_pkg::WORD_W-1:0] left_data,
   input  wire logic signed [bole_pkg::WORD_W-1:0] right_data,
   input  wire                                   seen_in,
   output logic signed [bole_pkg::WORD_W-1:0]    elem_out,
   output logic                                  seen_out
);

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic signed [bole_pkg::WORD_W-1:0] elem_ff, elem_in;
   logic                               match_ff, match_in;

   // match only counts for occupied slots
   assign match_in = (elem_ff == ctrl.value) && (IDX < count);

   // this cell is at or past the first match in the row
   assign seen_out = seen_in | match_ff;
   assign elem_out = elem_ff;

   // element update
   always_comb begin
      elem_in = elem_ff;
      case (ctrl.mode)
         bole_pkg::CELL_OPEN: begin
            if (IDX > pos) elem_in = left_data;
            else if (IDX == pos) elem_in = ctrl.value;
         end
         bole_pkg::CELL_CLOSE_POS: begin
            if (IDX >= pos) elem_in = right_data;
         end
         bole_pkg::CELL_CLOSE_MATCH: begin
            if (seen_out) elem_in = right_data;
         end
         default: begin
            elem_in = elem_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
      if (ctrl.match_en) match_ff <= match_in;
   end

endmodule

`default_nettype wire

// File: rtl/bounded_ordered_list_engine.sv
// Bounded ordered list engine: a row of element cells under a small controller.
// Requests are taken one at a time: ready stays low until the previous result is
// being taken. The request transfer registers the key match in every cell, and
// the update cycle ripples first-match through the row and shifts it.
// Reset clears the count and handshake state; element contents are undefined
// until written and get no clearing pass.
// ----------------------------------------------------------------------------
// Bounded ordered list engine
// Top level: request decode, cell row, count register and response register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bounded_ordered_list_engine #(
   parameter int CAPACITY = 64
) (
   input wire   clock,
   input wire   reset,
   bole_req_if.sink   req,
   bole_rsp_if.source rsp
);

   localparam int            CW    = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   typedef enum logic {
      ST_IDLE,
      ST_EVAL
   } state_type;

   state_type                          state_ff;
   logic [CW-1:0]                      count_ff, count_in;
   bole_pkg::kind_type                 kind_ff;
   logic signed [bole_pkg::WORD_W-1:0] value_ff;
   logic [CW-1:0]                      pos_ff;

   logic                               rsp_valid_ff;
   bole_pkg::status_type               status_ff, status_in;
   logic                               present_ff, present_in;

   logic [CW-1:0]                      eff_pos;
   bole_pkg::cell_mode_type            mode_eval;
   bole_pkg::cell_ctrl_type            ctrl;
   logic                               req_fire;
   logic                               found;

   logic signed [bole_pkg::WORD_W-1:0] elem_w [CAPACITY];
   logic                               seen_w [CAPACITY+1];

   // handshake
   assign req.ready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req_fire    = req.valid && req.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.status  = status_ff;
   assign rsp.present = present_ff;
   assign rsp.length  = count_ff;

   // request decode on the update cycle
   always_comb begin
      eff_pos    = '0;
      mode_eval  = bole_pkg::CELL_HOLD;
      status_in  = bole_pkg::STATUS_OK;
      present_in = 1'b0;
      count_in   = count_ff;
      case (kind_ff)
         bole_pkg::KIND_ADD_FRONT, bole_pkg::KIND_ADD_BACK, bole_pkg::KIND_INSERT: begin
            if (kind_ff == bole_pkg::KIND_ADD_FRONT) eff_pos = '0;
            else if (kind_ff == bole_pkg::KIND_ADD_BACK) eff_pos = count_ff;
            else eff_pos = pos_ff;
            if (eff_pos > count_ff) begin
               status_in = bole_pkg::STATUS_BAD_POS;
            end else if (count_ff >= CAP_C) begin
               status_in = bole_pkg::STATUS_FULL;
            end else begin
               mode_eval = bole_pkg::CELL_OPEN;
               count_in  = count_ff + 1'b1;
            end
         end
         bole_pkg::KIND_REMOVE_FRONT: begin
            if (count_ff == '0) begin
               status_in = bole_pkg::STATUS_EMPTY;
            end else begin
               mode_eval = bole_pkg::CELL_CLOSE_POS;
               count_in  = count_ff - 1'b1;
            end
         end
         bole_pkg::KIND_REMOVE_BACK: begin
            if (count_ff == '0) status_in = bole_pkg::STATUS_EMPTY;
            else count_in = count_ff - 1'b1;
         end
         bole_pkg::KIND_REMOVE_KEY: begin
            if (!found) begin
               status_in = bole_pkg::STATUS_NOT_FOUND;
            end else begin
               mode_eval = bole_pkg::CELL_CLOSE_MATCH;
               count_in  = count_ff - 1'b1;
            end
         end
         bole_pkg::KIND_FIND: begin
            present_in = found;
         end
         default: begin
            status_in = bole_pkg::STATUS_OK;
         end
      endcase
   end

   // broadcast to the row: match capture on transfer, shift on update
   always_comb begin
      ctrl.mode     = (state_ff == ST_EVAL) ? mode_eval : bole_pkg::CELL_HOLD;
      ctrl.match_en = req_fire;
      ctrl.value    = req_fire ? req.value : value_ff;
   end

   // cell row; first-match ripples from the front
   assign seen_w[0] = 1'b0;
   assign found     = seen_w[CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [bole_pkg::WORD_W-1:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_mid_l
         assign left_d = elem_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = elem_w[i];
      end else begin : g_mid_r
         assign right_d = elem_w[i+1];
      end
      bole_cell #(
         .CW    (CW),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .pos        (eff_pos),
         .count      (count_ff),
         .left_data  (left_d),
         .right_data (right_d),
         .seen_in    (seen_w[i]),
         .elem_out   (elem_w[i]),
         .seen_out   (seen_w[i+1])
      );
   end

   // controller state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
               if (req_fire) begin
                  kind_ff  <= bole_pkg::kind_type'(req.kind);
                  value_ff <= req.value;
                  pos_ff   <= req.position;
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               count_ff     <= count_in;
               status_ff    <= status_in;
               present_ff   <= present_in;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `ASSERT_NEXT(a_accept_eval, clock, reset, req_fire, state_ff == ST_EVAL)
   `ASSERT_NEXT(a_eval_rsp, clock, reset, state_ff == ST_EVAL, rsp_valid_ff)
   `ASSERT_IMPLIES(a_count_cap, clock, reset, 1'b1, count_ff <= CAP_C)
   `ASSERT_NEXT(a_count_hold, clock, reset, state_ff != ST_EVAL, $stable(count_ff))

endmodule

`default_nettype wire

// File: tb/sv/bole_result_checker.sv
// ----------------------------------------------------------------------------
// Ordered list engine result checker
// Watches both channels, keeps a shadow copy of the list, predicts the result
// of every request transfer and compares each result transfer against it.
// ----------------------------------------------------------------------------
module bole_result_checker
   import bole_pkg::*;
#(
   parameter int CAPACITY = 64,
   parameter int CW       = 7
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   input  wire                     req_ready,
   input  wire [KIND_W-1:0]        req_kind,
   input  wire signed [WORD_W-1:0] req_value,
   input  wire [CW-1:0]            req_position,
   input  wire                     rsp_valid,
   input  wire                     rsp_ready,
   input  wire [STATUS_W-1:0]      rsp_status,
   input  wire                     rsp_present,
   input  wire [CW-1:0]            rsp_length,
   input  wire                     end_of_test,
   output int                      fail_count,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type    status;
      logic          present;
      logic [CW-1:0] length;
   } list_result_t;

   // shadow of the list, front at index 0
   logic signed [WORD_W-1:0] list_contents[$];
   list_result_t             expected_results[$];
   bit                       leftovers_reported;

   initial begin
      fail_count         = 0;
      pending            = 0;
      leftovers_reported = 1'b0;
   end

   // apply one request to the shadow list and return what the block should answer
   function automatic list_result_t apply_list_request(
      input logic [KIND_W-1:0]        kind,
      input logic signed [WORD_W-1:0] value,
      input logic [CW-1:0]            position
   );
      list_result_t r;
      int           at;
      int           hit;
      r.status  = STATUS_OK;
      r.present = 1'b0;
      hit       = -1;
      // first match, shared by remove key and find
      for (int i = 0; i < list_contents.size(); i++)
         if (hit < 0 && list_contents[i] == value) hit = i;
      case (kind)
         KIND_ADD_FRONT, KIND_ADD_BACK, KIND_INSERT: begin
            if (kind == KIND_ADD_FRONT) at = 0;
            else if (kind == KIND_ADD_BACK) at = list_contents.size();
            else at = int'(position);
            // position check takes priority over the full check
            if (at > list_contents.size()) r.status = STATUS_BAD_POS;
            else if (list_contents.size() >= CAPACITY) r.status = STATUS_FULL;
            else if (at == list_contents.size()) list_contents.push_back(value);
            else list_contents.insert(at, value);
         end
         KIND_REMOVE_FRONT: begin
            if (list_contents.size() == 0) r.status = STATUS_EMPTY;
            else void'(list_contents.pop_front());
         end
         KIND_REMOVE_BACK: begin
            if (list_contents.size() == 0) r.status = STATUS_EMPTY;
            else void'(list_contents.pop_back());
         end
         KIND_REMOVE_KEY: begin
            if (hit < 0) r.status = STATUS_NOT_FOUND;
            else list_contents.delete(hit);
         end
         KIND_FIND: begin
            r.present = (hit >= 0);
         end
         default: ;  // unused code: nothing changes
      endcase
      r.length = CW'(list_contents.size());
      return r;
   endfunction

   // result side first, then request side; both sampled on the rising edge
   always @(posedge clock) begin : watch
      list_result_t exp_r;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with nothing expected: status %0d length %0d",
                      rsp_status, rsp_length);
               fail_count++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_status !== exp_r.status) begin
                  $error("status: expected %0d, actual %0d", exp_r.status, rsp_status);
                  fail_count++;
               end
               if (rsp_present !== exp_r.present) begin
                  $error("present: expected %0d, actual %0d", exp_r.present, rsp_present);
                  fail_count++;
               end
               if (rsp_length !== exp_r.length) begin
                  $error("length: expected %0d, actual %0d", exp_r.length, rsp_length);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(apply_list_request(req_kind, req_value, req_position));
         if (end_of_test && !leftovers_reported) begin
            leftovers_reported = 1'b1;
            if (expected_results.size() != 0) begin
               $error("%0d expected results never arrived", expected_results.size());
               fail_count += expected_results.size();
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Drives directed then randomised list requests with random idling on both
// channels, a long result hold-off and a drain pause; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bole_pkg::*;

   localparam int          LIST_CAPACITY  = 64;
   localparam int          CW             = 7;
   localparam int          ITEM_TARGET    = 850;
   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          PAUSE_AT       = 300;
   localparam int          CALM_FIRST     = 400;
   localparam int          CALM_LAST      = 560;
   localparam int          HOLD_START     = 700;
   localparam int          HOLD_LEN       = 60;
   localparam int          RX_CALM_FIRST  = 1000;
   localparam int          RX_CALM_LAST   = 1300;
   localparam int          IDLE_PERCENT   = 7;
   localparam logic [2:0]  KIND_UNUSED    = 3'd7;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_ANY} traffic_mix_type;

   logic          clock;
   logic          reset;
   logic          end_of_test;
   logic          no_idle;
   logic [CW-1:0] last_length;
   int            fail_count;
   int            pending;

   bole_req_if #(.CW(CW)) req_ch ();
   bole_rsp_if #(.CW(CW)) rsp_ch ();

   bounded_ordered_list_engine #(.CAPACITY(LIST_CAPACITY)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   bole_result_checker #(.CAPACITY(LIST_CAPACITY), .CW(CW)) checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_ready    (req_ch.ready),
      .req_kind     (req_ch.kind),
      .req_value    (req_ch.value),
      .req_position (req_ch.position),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_status   (rsp_ch.status),
      .rsp_present  (rsp_ch.present),
      .rsp_length   (rsp_ch.length),
      .end_of_test  (end_of_test),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // last length seen, steers insert positions towards the live range
   initial last_length = '0;
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready) last_length <= rsp_ch.length;
   end

   // result side: random back-pressure, one long hold-off, one calm stretch
   initial begin : receiver
      int cyc;
      cyc = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) rsp_ch.ready <= 1'b0;
         else if (cyc >= RX_CALM_FIRST && cyc < RX_CALM_LAST) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // watchdog: too long without any transfer on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb failed");
      $finish;
   end

   // one request transfer; called and returns at a falling edge
   task automatic issue(input logic [2:0] k, input logic signed [31:0] v,
                        input logic [CW-1:0] p);
      req_ch.valid    <= 1'b1;
      req_ch.kind     <= k;
      req_ch.value    <= v;
      req_ch.position <= p;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
      if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   // hold the request side until every outstanding result has come back
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // mostly a small pool so keys repeat and match, sometimes any word
   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] pool [8];
      pool = '{32'sd0, 32'sd1, -32'sd1, 32'sd7, -32'sd7, 32'sd100,
               32'sh7fff_ffff, 32'sh8000_0000};
      if ($urandom_range(0, 99) < 70) return pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic logic [CW-1:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return CW'($urandom_range(0, last_length));
      if (r < 85) return (last_length < LIST_CAPACITY) ? last_length + 1'b1 : CW'(LIST_CAPACITY);
      return CW'($urandom_range(0, LIST_CAPACITY));
   endfunction

   function automatic logic [2:0] pick_kind(input traffic_mix_type mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (r < 30) return KIND_ADD_FRONT;
            if (r < 55) return KIND_ADD_BACK;
            if (r < 75) return KIND_INSERT;
            if (r < 82) return KIND_FIND;
            if (r < 89) return KIND_REMOVE_KEY;
            if (r < 93) return KIND_REMOVE_FRONT;
            if (r < 97) return KIND_REMOVE_BACK;
            return KIND_UNUSED;
         end
         MIX_DRAIN: begin
            if (r < 25) return KIND_REMOVE_FRONT;
            if (r < 50) return KIND_REMOVE_BACK;
            if (r < 70) return KIND_REMOVE_KEY;
            if (r < 80) return KIND_FIND;
            if (r < 86) return KIND_ADD_FRONT;
            if (r < 92) return KIND_ADD_BACK;
            if (r < 97) return KIND_INSERT;
            return KIND_UNUSED;
         end
         default: return 3'($urandom_range(0, 7));
      endcase
   endfunction

   // stimulus and verdict
   initial begin : stimulus
      traffic_mix_type mix;
      int              mix_left;
      int              n;
      req_ch.valid    = 1'b0;
      req_ch.kind     = '0;
      req_ch.value    = '0;
      req_ch.position = '0;
      end_of_test     = 1'b0;
      no_idle         = 1'b0;
      reset           = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty list cases first
      issue(KIND_REMOVE_FRONT, pick_value(), pick_position());
      issue(KIND_REMOVE_BACK, pick_value(), pick_position());
      issue(KIND_REMOVE_KEY, 32'sd0, pick_position());
      issue(KIND_FIND, 32'sd0, pick_position());
      issue(KIND_UNUSED, $urandom, 7'd127);
      issue(KIND_INSERT, 32'sd3, 7'd1);                    // past the count
      issue(KIND_INSERT, 32'sd3, 7'd64);                   // past the count, top bit
      // build [-1, MIN, 7, MAX, 0, 7]
      issue(KIND_INSERT, 32'sh8000_0000, 7'd0);
      issue(KIND_ADD_BACK, 32'sh7fff_ffff, 7'd0);
      issue(KIND_ADD_FRONT, -32'sd1, 7'd63);
      issue(KIND_INSERT, 32'sd0, 7'd3);                    // at the count: append
      issue(KIND_INSERT, 32'sd7, 7'd2);
      issue(KIND_ADD_BACK, 32'sd7, 7'd0);                  // duplicate key
      issue(KIND_FIND, 32'sd7, 7'd0);
      issue(KIND_FIND, 32'sd8, 7'd0);
      issue(KIND_REMOVE_KEY, 32'sd7, 7'd0);                // first of two only
      issue(KIND_REMOVE_KEY, 32'sd9, 7'd0);
      issue(KIND_REMOVE_FRONT, 32'sd0, 7'd0);
      issue(KIND_REMOVE_BACK, 32'sd0, 7'd0);
      issue(KIND_UNUSED, 32'sd0, 7'd5);
      issue(KIND_REMOVE_KEY, 32'sh8000_0000, 7'd0);
      issue(KIND_REMOVE_FRONT, 32'sd0, 7'd0);
      issue(KIND_REMOVE_BACK, 32'sd0, 7'd0);               // only element by the back
      issue(KIND_ADD_FRONT, 32'sd5, 7'd0);
      issue(KIND_REMOVE_KEY, 32'sd5, 7'd0);                // only element by key
      wait_for_results();

      // random: fill first so the full list is reached early, then mixed episodes
      mix      = MIX_FILL;
      mix_left = 150;
      for (n = 0; n < ITEM_TARGET; n++) begin
         if (mix_left == 0) begin
            mix      = traffic_mix_type'($urandom_range(0, 2));
            mix_left = $urandom_range(60, 140);
         end
         mix_left--;
         if (n == PAUSE_AT) wait_for_results();
         no_idle = (n >= CALM_FIRST && n < CALM_LAST);
         issue(pick_kind(mix), pick_value(), pick_position());
      end
      req_ch.valid <= 1'b0;

      // drain, allow the block's latency, then close out
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      end_of_test <= 1'b1;
      repeat (2) @(negedge clock);
      if (fail_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

// File: bounded_ordered_list_engine.f
+incdir+rtl
rtl/bole_pkg.sv
rtl/bole_channels.sv
rtl/bole_cell.sv
rtl/bounded_ordered_list_engine.sv
tb/sv/bole_result_checker.sv
tb/sv/tb.sv
